/* rtl/fss_pkg.sv */
// Shared types and constants for the FFT size shrink selector.
// Used by fss_div and fft_size_shrink_selector_core; depends on nothing else.
`timescale 1ns / 1ps

package fss_pkg;

   // Width of the sizes that are searched and factored.
   localparam int SIZE_BITS   = 16;

   // Field widths of the ports.
   localparam int DIM_W   = 16;
   localparam int SIZE_W  = 16;
   localparam int COST_W  = 16;
   localparam int CROP_W  = 15;
   localparam int SHRINK_W = 14;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Shrink register: full scale is 100 percent in hundredths of a percent.
   localparam logic [SHRINK_W-1:0] SHRINK_FULL  = SHRINK_W'(10000);
   localparam logic [SHRINK_W-1:0] SHRINK_RESET = SHRINK_W'(100);

   // Register index decoded from the word address.
   localparam logic CSR_IDX_SHRINK = 1'b0;

   // Trial division tries every divisor from 2 up to this bound, the 460th prime.
   localparam int LAST_PRIME = 3257;
   // Trial divisor width: it counts up to one past the last prime.
   localparam int D_W   = $clog2(LAST_PRIME + 2);
   localparam int SQ_W  = 2 * D_W;
   // Divider widths: the product n * (full - shrink) and the widest divisor.
   localparam int PROD_W = SIZE_BITS + SHRINK_W;
   localparam int DIV_W  = (D_W > SHRINK_W) ? D_W : SHRINK_W;
   localparam int CNT_W  = $clog2(PROD_W + 1);

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SDIV_GO,
      ST_SDIV_WAIT,
      ST_COST_CHECK,
      ST_COST_WAIT,
      ST_COST_END,
      ST_OUT
   } seq_state_type;

   // Request to the shared divider.
   typedef struct packed {
      logic launch;
      logic wide;
   } div_ctl_type;

   // Status and results of the shared divider.
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SIZE_BITS-1:0] quotient;
      logic [DIV_W-1:0]     remainder;
   } div_stat_type;

endpackage

/* rtl/fss_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on fss_pkg for widths and the control and status structs.
`timescale 1ns / 1ps

module fss_div (
   input  logic                          clock,
   input  logic                          reset,
   input  fss_pkg::div_ctl_type          ctl,
   input  logic [fss_pkg::PROD_W-1:0]    dividend,
   input  logic [fss_pkg::DIV_W-1:0]     divisor,
   output fss_pkg::div_stat_type         stat
);

   logic [fss_pkg::PROD_W-1:0] q_ff, q_in;
   logic [fss_pkg::DIV_W-1:0]  r_ff, r_in;
   logic [fss_pkg::DIV_W-1:0]  divisor_ff, divisor_in;
   logic [fss_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic [fss_pkg::DIV_W:0]    shifted;
   logic [fss_pkg::DIV_W+1:0]  diff;
   logic                       neg;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted = {r_ff, q_ff[fss_pkg::PROD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      neg     = diff[fss_pkg::DIV_W+1];
   end

   // A narrow division loads the value at the top so only SIZE_BITS steps run.
   always_comb begin
      q_in       = q_ff;
      r_in       = r_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      if (ctl.launch) begin
         if (ctl.wide) begin
            q_in   = dividend;
            cnt_in = fss_pkg::CNT_W'(fss_pkg::PROD_W);
         end else begin
            q_in   = {dividend[fss_pkg::SIZE_BITS-1:0],
                      {(fss_pkg::PROD_W - fss_pkg::SIZE_BITS){1'b0}}};
            cnt_in = fss_pkg::CNT_W'(fss_pkg::SIZE_BITS);
         end
         r_in       = '0;
         divisor_in = divisor;
      end else if (cnt_ff != '0) begin
         q_in    = {q_ff[fss_pkg::PROD_W-2:0], ~neg};
         r_in    = neg ? shifted[fss_pkg::DIV_W-1:0] : diff[fss_pkg::DIV_W-1:0];
         cnt_in  = cnt_ff - fss_pkg::CNT_W'(1);
         done_in = (cnt_ff == fss_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff       <= q_in;
      r_ff       <= r_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy      = (cnt_ff != '0);
   assign stat.done      = done_ff;
   assign stat.quotient  = q_ff[fss_pkg::SIZE_BITS-1:0];
   assign stat.remainder = r_ff;

endmodule

/* rtl/fft_size_shrink_selector_core.sv */
// Top level of the FFT size shrink selector: sequencer, cost search and register port.
// Depends on fss_pkg and the shared divider fss_div.
// Steps: a wide division finds the search start, then each candidate size is costed by
// trial divisions (about sqrt(size) plus its factor count), then the result is loaded;
// one item is worked on at a time, one result per item.
// Reset clears the sequencer and the result valid and sets the shrink register to 100.
`timescale 1ns / 1ps

module fft_size_shrink_selector_core (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fss_pkg::DIM_W-1:0]   req_dimension,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fss_pkg::SIZE_W-1:0]  rsp_best_size,
   output logic [fss_pkg::COST_W-1:0]  rsp_best_cost,
   output logic [fss_pkg::COST_W-1:0]  rsp_original_cost,
   output logic [fss_pkg::CROP_W-1:0]  rsp_crop_offset,
   // Configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [fss_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [fss_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [fss_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int SB = fss_pkg::SIZE_BITS;

   fss_pkg::seq_state_type state_ff, state_in;

   logic [fss_pkg::SHRINK_W-1:0] shrink_ff, shrink_in;
   logic [SB-1:0]                n_ff, n_in;
   logic [fss_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [SB-1:0]                x_ff, x_in;
   logic [SB-1:0]                rem_ff, rem_in;
   logic [fss_pkg::D_W-1:0]      d_ff, d_in;
   logic [SB-1:0]                cost_ff, cost_in;
   logic [SB-1:0]                best_ff, best_in;
   logic [SB-1:0]                best_cost_ff, best_cost_in;
   logic [SB-1:0]                orig_cost_ff, orig_cost_in;
   logic                         have_ff, have_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fss_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic [fss_pkg::COST_W-1:0]   rsp_cost_ff, rsp_cost_in;
   logic [fss_pkg::COST_W-1:0]   rsp_orig_ff, rsp_orig_in;
   logic [fss_pkg::CROP_W-1:0]   rsp_crop_ff, rsp_crop_in;

   fss_pkg::div_ctl_type         div_ctl;
   fss_pkg::div_stat_type        div_stat;
   logic [fss_pkg::PROD_W-1:0]   div_dividend;
   logic [fss_pkg::DIV_W-1:0]    div_divisor;

   logic                         in_accept;
   logic                         csr_write;
   logic [SB-1:0]                dim_held;
   logic [fss_pkg::SHRINK_W-1:0] shrink_sat;
   logic [fss_pkg::SQ_W-1:0]     d_square;
   logic                         trial_go;
   logic [SB-1:0]                start_size;
   logic                         out_free;

   assign in_accept = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Input item: take the low SIZE_BITS bits and hold zero to one.
   always_comb begin
      dim_held = SB'(req_dimension);
      if (dim_held == '0) begin
         dim_held = SB'(1);
      end
      shrink_sat = (shrink_ff > fss_pkg::SHRINK_FULL) ? fss_pkg::SHRINK_FULL : shrink_ff;
   end

   // Trial division goes on while the cofactor may still split.
   always_comb begin
      d_square = d_ff * d_ff;
      trial_go = (rem_ff > SB'(1))
              && (d_ff <= fss_pkg::D_W'(fss_pkg::LAST_PRIME))
              && (d_square <= fss_pkg::SQ_W'(rem_ff));
   end

   // The search never starts below size one.
   always_comb begin
      start_size = div_stat.quotient;
      if (start_size == '0) begin
         start_size = SB'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fss_pkg::ST_IDLE: begin
            if (in_accept) begin
               state_in = fss_pkg::ST_MUL;
            end
         end
         fss_pkg::ST_MUL: begin
            state_in = fss_pkg::ST_SDIV_GO;
         end
         fss_pkg::ST_SDIV_GO: begin
            state_in = fss_pkg::ST_SDIV_WAIT;
         end
         fss_pkg::ST_SDIV_WAIT: begin
            if (div_stat.done) begin
               state_in = fss_pkg::ST_COST_CHECK;
            end
         end
         fss_pkg::ST_COST_CHECK: begin
            state_in = trial_go ? fss_pkg::ST_COST_WAIT : fss_pkg::ST_COST_END;
         end
         fss_pkg::ST_COST_WAIT: begin
            if (div_stat.done) begin
               state_in = fss_pkg::ST_COST_CHECK;
            end
         end
         fss_pkg::ST_COST_END: begin
            state_in = (x_ff == n_ff) ? fss_pkg::ST_OUT : fss_pkg::ST_COST_CHECK;
         end
         fss_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = fss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fss_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshake and divider requests.
   always_comb begin
      req_ready      = 1'b0;
      div_ctl.launch = 1'b0;
      div_ctl.wide   = 1'b0;
      div_dividend   = fss_pkg::PROD_W'(rem_ff);
      div_divisor    = fss_pkg::DIV_W'(d_ff);
      unique case (state_ff)
         fss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         fss_pkg::ST_SDIV_GO: begin
            div_ctl.launch = 1'b1;
            div_ctl.wide   = 1'b1;
            div_dividend   = prod_ff;
            div_divisor    = fss_pkg::DIV_W'(fss_pkg::SHRINK_FULL);
         end
         fss_pkg::ST_COST_CHECK: begin
            div_ctl.launch = trial_go;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath: search window, factor cost and best candidate.
   always_comb begin
      n_in         = n_ff;
      prod_in      = prod_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      d_in         = d_ff;
      cost_in      = cost_ff;
      best_in      = best_ff;
      best_cost_in = best_cost_ff;
      orig_cost_in = orig_cost_ff;
      have_in      = have_ff;
      unique case (state_ff)
         fss_pkg::ST_IDLE: begin
            if (in_accept) begin
               n_in    = dim_held;
               have_in = 1'b0;
            end
         end
         fss_pkg::ST_MUL: begin
            prod_in = n_ff * (fss_pkg::SHRINK_FULL - shrink_sat);
         end
         fss_pkg::ST_SDIV_WAIT: begin
            if (div_stat.done) begin
               x_in    = start_size;
               rem_in  = start_size;
               d_in    = fss_pkg::D_W'(2);
               cost_in = '0;
            end
         end
         fss_pkg::ST_COST_CHECK: begin
            // A cofactor that is left over counts as one factor.
            if (!trial_go) begin
               cost_in = cost_ff + rem_ff - SB'(1);
            end
         end
         fss_pkg::ST_COST_WAIT: begin
            if (div_stat.done) begin
               if (div_stat.remainder == '0) begin
                  cost_in = cost_ff + SB'(d_ff) - SB'(1);
                  rem_in  = div_stat.quotient;
               end else begin
                  d_in = d_ff + fss_pkg::D_W'(1);
               end
            end
         end
         fss_pkg::ST_COST_END: begin
            // Ties go to the larger size, which is always the later one.
            if (!have_ff || cost_ff <= best_cost_ff) begin
               best_in      = x_ff;
               best_cost_in = cost_ff;
               have_in      = 1'b1;
            end
            if (x_ff == n_ff) begin
               orig_cost_in = cost_ff;
            end else begin
               x_in    = x_ff + SB'(1);
               rem_in  = x_ff + SB'(1);
               d_in    = fss_pkg::D_W'(2);
               cost_in = '0;
            end
         end
         default: begin
            n_in = n_ff;
         end
      endcase
   end

   // Result register: loaded once the previous item has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_orig_in  = rsp_orig_ff;
      rsp_crop_in  = rsp_crop_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == fss_pkg::ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_size_in  = fss_pkg::SIZE_W'(best_ff);
         rsp_cost_in  = fss_pkg::COST_W'(best_cost_ff);
         rsp_orig_in  = fss_pkg::COST_W'(orig_cost_ff);
         rsp_crop_in  = fss_pkg::CROP_W'((n_ff - best_ff) >> 1);
      end
   end

   // Shrink register write.
   always_comb begin
      shrink_in = shrink_ff;
      if (csr_write && csr_paddr[2] == fss_pkg::CSR_IDX_SHRINK) begin
         shrink_in = csr_pwdata[fss_pkg::SHRINK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fss_pkg::ST_IDLE;
         shrink_ff    <= fss_pkg::SHRINK_RESET;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shrink_ff    <= shrink_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      prod_ff      <= prod_in;
      x_ff         <= x_in;
      rem_ff       <= rem_in;
      d_ff         <= d_in;
      cost_ff      <= cost_in;
      best_ff      <= best_in;
      best_cost_ff <= best_cost_in;
      orig_cost_ff <= orig_cost_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_orig_ff  <= rsp_orig_in;
      rsp_crop_ff  <= rsp_crop_in;
   end

   // Shared divider for the search start and every trial division.
   fss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat)
   );

   // Register read back and port outputs.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == fss_pkg::CSR_IDX_SHRINK)
                     ? fss_pkg::CSR_DW'(shrink_ff) : '0;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_size     = rsp_size_ff;
   assign rsp_best_cost     = rsp_cost_ff;
   assign rsp_original_cost = rsp_orig_ff;
   assign rsp_crop_offset   = rsp_crop_ff;

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_ctl.launch |-> !div_stat.busy)
      else $error("divider started while busy");

   // A divider result follows a running division.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> $past(div_stat.busy))
      else $error("divider done without a running division");

   // The cofactor under test never leaves the range of the candidate.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fss_pkg::ST_COST_CHECK |-> (rem_ff != '0 && rem_ff <= x_ff))
      else $error("cofactor out of range");

   // The chosen size lies within the dimension when the result is loaded.
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fss_pkg::ST_OUT |-> (have_ff && best_ff != '0 && best_ff <= n_ff))
      else $error("best size out of range");

   // The trial divisor never runs past one beyond the last prime.
   a_d_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fss_pkg::ST_COST_CHECK
         |-> d_ff <= fss_pkg::D_W'(fss_pkg::LAST_PRIME + 1))
      else $error("trial divisor out of range");

endmodule

/* tb/sv/fft_size_shrink_selector_core_tb.sv */
// Self-checking testbench for fft_size_shrink_selector_core: shrink register writes and
// readback, directed and random dimensions, with the expected size choice predicted here.
// Depends on fss_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

module fft_size_shrink_selector_core_tb;
   import fss_pkg::*;

   // One expected or observed result item.
   typedef struct packed {
      logic [SIZE_W-1:0] best_size;
      logic [COST_W-1:0] best_cost;
      logic [COST_W-1:0] original_cost;
      logic [CROP_W-1:0] crop_offset;
   } size_choice_type;

   localparam logic [CSR_AW-1:0] SHRINK_ADDR = '0;
   localparam int unsigned SHRINK_SCALE = 10000;
   localparam int unsigned SHRINK_DEFAULT = 100;
   localparam int unsigned SHRINK_TOP = 16383;
   localparam int unsigned LONG_HOLD_CYCLES = 2000;
   localparam int unsigned WATCHDOG_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 60;
   // Rough ceiling on the core's cycles for one random item.
   localparam int unsigned SEARCH_BUDGET = 10000;

   // Keeps the configured shrink and the queue of expected size choices.
   class shrink_scoreboard;
      int unsigned shrink_q;
      size_choice_type expected_choices[$];
      int unsigned mismatch_count;

      function new();
         shrink_q = SHRINK_DEFAULT;
         mismatch_count = 0;
      endfunction

      // Sum of (prime factor - 1) by trial division. For 16-bit sizes the square
      // root stays far below LAST_PRIME, the bound of the core's trial divisor.
      function int unsigned size_cost(int unsigned v);
         int unsigned d;
         int unsigned total;
         total = 0;
         d = 2;
         while (v > 1 && d * d <= v) begin
            if (v % d == 0) begin
               total += d - 1;
               v = v / d;
            end else begin
               d++;
            end
         end
         if (v > 0) begin
            total += v - 1;
         end
         return total;
      endfunction

      function void flag(string what, int unsigned want, int unsigned seen);
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("MISMATCH %s: expected %0d, got %0d", what, want, seen);
         end
      endfunction

      // Works out the size choice for an accepted dimension.
      function void note_dimension(logic [DIM_W-1:0] dim);
         int unsigned n;
         int unsigned q;
         int unsigned first;
         int unsigned x;
         int unsigned c;
         int unsigned best;
         int unsigned best_c;
         size_choice_type choice;
         n = (dim == '0) ? 1 : int'(dim);
         q = (shrink_q > SHRINK_SCALE) ? SHRINK_SCALE : shrink_q;
         first = (n * (SHRINK_SCALE - q)) / SHRINK_SCALE;
         if (first < 1) begin
            first = 1;
         end
         best = first;
         best_c = size_cost(first);
         // Ties go to the larger size, hence the less-or-equal.
         for (x = first + 1; x <= n; x++) begin
            c = size_cost(x);
            if (c <= best_c) begin
               best = x;
               best_c = c;
            end
         end
         choice.best_size = SIZE_W'(best);
         choice.best_cost = COST_W'(best_c);
         choice.original_cost = COST_W'(size_cost(n));
         choice.crop_offset = CROP_W'((n - best) / 2);
         expected_choices.push_back(choice);
      endfunction

      // Compares an accepted result item with the oldest expectation.
      function void check_result(size_choice_type seen);
         size_choice_type want;
         if (expected_choices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("MISMATCH result item with nothing outstanding: best_size %0d",
                        seen.best_size);
            end
         end else begin
            want = expected_choices.pop_front();
            if (seen.best_size !== want.best_size) begin
               flag("best_size", want.best_size, seen.best_size);
            end
            if (seen.best_cost !== want.best_cost) begin
               flag("best_cost", want.best_cost, seen.best_cost);
            end
            if (seen.original_cost !== want.original_cost) begin
               flag("original_cost", want.original_cost, seen.original_cost);
            end
            if (seen.crop_offset !== want.crop_offset) begin
               flag("crop_offset", want.crop_offset, seen.crop_offset);
            end
         end
      endfunction

      function void check_shrink_readback(logic [CSR_DW-1:0] seen);
         if (seen !== CSR_DW'(shrink_q)) begin
            flag("shrink register readback", shrink_q, seen);
         end
      endfunction

      function bit clean();
         return mismatch_count == 0 && expected_choices.size() == 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [DIM_W-1:0] req_dimension;
   logic rsp_valid;
   logic rsp_ready;
   logic [SIZE_W-1:0] rsp_best_size;
   logic [COST_W-1:0] rsp_best_cost;
   logic [COST_W-1:0] rsp_original_cost;
   logic [CROP_W-1:0] rsp_crop_offset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   shrink_scoreboard board;
   int unsigned tx_run_left = 0;
   int unsigned rx_run_left = 0;
   bit long_hold = 1'b0;

   fft_size_shrink_selector_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_dimension(req_dimension),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_best_size(rsp_best_size),
      .rsp_best_cost(rsp_best_cost),
      .rsp_original_cost(rsp_original_cost),
      .rsp_crop_offset(rsp_crop_offset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle gap before the next item, drawn at random, with occasional runs of no idling.
   function automatic int unsigned draw_gap(inout int unsigned run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         run_left = $urandom_range(4, 12);
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic int unsigned isqrt(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) begin
         r++;
      end
      return r;
   endfunction

   // Pessimistic cycle count of one search, from the core's step sequence.
   function automatic int unsigned search_cycles(int unsigned dim, int unsigned q);
      int unsigned n;
      int unsigned first;
      n = (dim == 0) ? 1 : dim;
      if (q > SHRINK_SCALE) begin
         q = SHRINK_SCALE;
      end
      first = (n * (SHRINK_SCALE - q)) / SHRINK_SCALE;
      return 40 + (n - first + 2) * (3 + 19 * (isqrt(n) + 17));
   endfunction

   // Random dimension of random bit length whose search stays within the budget.
   function automatic logic [DIM_W-1:0] pick_dimension(int unsigned q);
      int unsigned tries;
      int unsigned w;
      int unsigned n;
      for (tries = 0; tries < 64; tries++) begin
         w = $urandom_range(1, DIM_W);
         n = $urandom & ((1 << w) - 1);
         if (search_cycles(n, q) <= SEARCH_BUDGET) begin
            return DIM_W'(n);
         end
      end
      return DIM_W'($urandom_range(0, 15));
   endfunction

   // Offers one item; valid stays high afterwards so the next item can follow at once.
   task automatic send_dimension(input logic [DIM_W-1:0] dim);
      int unsigned gap;
      gap = draw_gap(tx_run_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dimension <= dim;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_dimension(dim);
   endtask

   // Drops valid after the last item and waits for every expected result.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register access: setup phase, access phase, then an idle phase.
   task automatic csr_access(input bit is_write, input logic [CSR_DW-1:0] value,
                             output logic [CSR_DW-1:0] read_value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= SHRINK_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      read_value = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_shrink();
      logic [CSR_DW-1:0] seen;
      csr_access(1'b0, '0, seen);
      board.check_shrink_readback(seen);
   endtask

   // Changes the shrink between phases, once the core is idle.
   task automatic change_shrink(input int unsigned value);
      logic [CSR_DW-1:0] unused;
      drain_results();
      csr_access(1'b1, CSR_DW'(value), unused);
      board.shrink_q = value & SHRINK_TOP;
      read_shrink();
   endtask

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin
      int unsigned gap;
      size_choice_type seen;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            gap = LONG_HOLD_CYCLES;
            long_hold = 1'b0;
         end else begin
            gap = draw_gap(rx_run_left);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         seen.best_size = rsp_best_size;
         seen.best_cost = rsp_best_cost;
         seen.original_cost = rsp_original_cost;
         seen.crop_offset = rsp_crop_offset;
         board.check_result(seen);
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence: directed phases, the stall phase, then random phases.
   initial begin
      int unsigned random_shrinks[7];
      int unsigned p;
      int unsigned k;
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_dimension <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset value of the shrink, then small sizes, zero, primes and a power of two.
      read_shrink();
      send_dimension(16'd0);
      send_dimension(16'd1);
      send_dimension(16'd2);
      send_dimension(16'd3);
      send_dimension(16'd97);
      send_dimension(16'd101);
      send_dimension(16'd1024);
      send_dimension(16'd1021);

      // No shrink: the widest dimensions, including the largest 16-bit prime.
      change_shrink(0);
      send_dimension(16'hFFFF);
      send_dimension(16'd65521);
      send_dimension(16'h8000);
      send_dimension(16'hFFFE);

      // Full shrink: the search starts at one.
      change_shrink(SHRINK_SCALE);
      send_dimension(16'd2);
      send_dimension(16'd12);
      send_dimension(16'd120);

      // Equal costs within the range, where the larger size must win.
      change_shrink(2500);
      send_dimension(16'd4);
      send_dimension(16'd8);

      // Shrink beyond full scale is held to full scale.
      change_shrink(SHRINK_TOP);
      send_dimension(16'd17);
      send_dimension(16'd100);

      // Quick items while the receiver holds off, so the core stalls its input.
      change_shrink(0);
      long_hold = 1'b1;
      for (k = 0; k < 8; k++) begin
         send_dimension(DIM_W'($urandom_range(1, 200)));
      end

      // Random phases over several shrink settings.
      random_shrinks[0] = 1;
      random_shrinks[1] = $urandom_range(0, SHRINK_SCALE);
      random_shrinks[2] = 500;
      random_shrinks[3] = 0;
      random_shrinks[4] = $urandom_range(0, SHRINK_TOP);
      random_shrinks[5] = SHRINK_SCALE;
      random_shrinks[6] = $urandom_range(0, 300);
      for (p = 0; p < 7; p++) begin
         change_shrink(random_shrinks[p]);
         for (k = 0; k < 10; k++) begin
            send_dimension(pick_dimension(board.shrink_q));
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.clean()) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/fss_pkg.sv
rtl/fss_div.sv
rtl/fft_size_shrink_selector_core.sv
tb/sv/fft_size_shrink_selector_core_tb.sv
